### src/assert_macros.svh
// Assertion macros for the bit reader RTL, used by its back part.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every edge outside reset.
`define MSBR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked on every edge outside reset.
`define MSBR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define MSBR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/msbr_pkg.sv
// Types, codes and constants of the MSB-first bit reader.
// No dependencies; imported by the modules of the block and by its bench.
`timescale 1ns / 1ps

package msbr_pkg;

	localparam int BUFFER_BITS_DEF = 64;
	localparam int QDEPTH          = 2;
	localparam int QAW             = $clog2(QDEPTH);

	localparam logic [1:0] FUNC_PUSH = 2'd0;
	localparam logic [1:0] FUNC_READ = 2'd1;
	localparam logic [1:0] FUNC_PEEK = 2'd2;
	localparam logic [1:0] FUNC_ECHO = 2'd3;

	localparam logic [1:0] KIND_FIELD = 2'd0;
	localparam logic [1:0] KIND_ECHO  = 2'd1;
	localparam logic [1:0] KIND_PUSH  = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_UNDERRUN = 2'd2;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_READ,
		OP_PEEK,
		OP_ECHO,
		OP_BAD
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data_b;
		logic [5:0] n;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic {
		BK_IDLE,
		BK_ECHO
	} bk_state_t;

endpackage

### src/msbr_in_if.sv
// Request channel of the bit reader: valid, ready and one request item.
// Depends on nothing.
`timescale 1ns / 1ps

interface msbr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] byte_in;
	logic [5:0] n_bits;

	modport source (output valid, output func, output byte_in, output n_bits, input ready);
	modport sink   (input valid, input func, input byte_in, input n_bits, output ready);
endinterface

### src/msbr_out_if.sv
// Result channel of the bit reader: valid, ready and one result item.
// Depends on nothing.
`timescale 1ns / 1ps

interface msbr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [56:0] value;
	logic [7:0]  byte_out;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, output kind, output value, output byte_out,
		output status, output last, input ready);
	modport sink   (input valid, input kind, input value, input byte_out,
		input status, input last, output ready);
endinterface

### src/msbr_front.sv
// Front part: accepts request items and classifies them into commands.
// Depends on msbr_pkg and msbr_in_if.
`timescale 1ns / 1ps

module msbr_front import msbr_pkg::*; #(
	parameter int BUFFER_BITS = BUFFER_BITS_DEF
) (
	msbr_in_if.sink  req,
	input  q_stat_t  qs,
	output logic     push,
	output cmd_t     cmd
);

	localparam logic [6:0] NMAX = 7'(BUFFER_BITS - 7);

	logic bad_n;

	assign bad_n     = (req.n_bits == 6'd0) || ({1'b0, req.n_bits} > NMAX);
	assign req.ready = !qs.full;
	assign push      = req.valid && !qs.full;

	always_comb begin
		cmd.data_b = req.byte_in;
		cmd.n      = req.n_bits;
		unique case (req.func)
			FUNC_PUSH: cmd.op = OP_PUSH;
			FUNC_READ: cmd.op = bad_n ? OP_BAD : OP_READ;
			FUNC_PEEK: cmd.op = bad_n ? OP_BAD : OP_PEEK;
			FUNC_ECHO: cmd.op = bad_n ? OP_BAD : OP_ECHO;
			default:   cmd.op = OP_BAD;
		endcase
	end

endmodule

### src/msbr_queue.sv
// Short command queue between the front and back parts.
// Depends on msbr_pkg.
`timescale 1ns / 1ps

module msbr_queue import msbr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    wr_cmd,
	input  logic    pop,
	output cmd_t    rd_cmd,
	output q_stat_t qs
);

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QAW:0]   cnt_q;
	logic           do_push;
	logic           do_pop;

	assign qs.full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign qs.empty = (cnt_q == '0);
	assign do_push  = push && !qs.full;
	assign do_pop   = pop && !qs.empty;
	assign rd_cmd   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + 1'b1;
			if (do_pop) rp_q <= rp_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= wr_cmd;
	end

endmodule

### src/msbr_back.sv
// Back part: holds the shift buffer and position, carries out commands,
// steps through echo bytes and drives the result register.
// Depends on msbr_pkg, msbr_out_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msbr_back import msbr_pkg::*; #(
	parameter int BUFFER_BITS = BUFFER_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  q_stat_t   qs,
	output logic      pop,
	msbr_out_if.source rsp
);

	localparam logic [6:0] BB7 = 7'(BUFFER_BITS);

	bk_state_t   st_q, st_d;
	logic [63:0] buf_q;
	logic [6:0]  cons_q;
	logic [56:0] val_q;
	logic [7:0]  sh_q;
	logic [6:0]  lo_q;

	logic        ov_q;
	logic [1:0]  kind_q;
	logic [56:0] value_q;
	logic [7:0]  byte_q;
	logic [1:0]  status_q;
	logic        last_q;

	logic        out_free;
	logic [6:0]  avail;
	logic [6:0]  lo;
	logic        under;
	logic [63:0] shifted;
	logic [63:0] mask;
	logic [63:0] field;
	logic [7:0]  echo_b;
	logic        emit;
	logic        go_echo;

	logic        ld;
	logic [1:0]  kind_d;
	logic [56:0] value_d;
	logic [7:0]  byte_d;
	logic [1:0]  status_d;
	logic        last_d;

	assign out_free = !ov_q || rsp.ready;
	assign avail    = BB7 - cons_q;
	assign lo       = avail - {1'b0, cmd.n};
	assign under    = (cmd.op == OP_BAD) || ({1'b0, cmd.n} > avail);
	assign shifted  = buf_q >> lo[5:0];
	assign mask     = (64'd1 << cmd.n) - 64'd1;
	assign field    = shifted & mask;
	assign echo_b   = 8'(buf_q >> sh_q[5:0]);
	assign emit     = !sh_q[7] && (sh_q[6:0] >= lo_q);
	assign go_echo  = pop && (cmd.op == OP_ECHO) && !under;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (go_echo) st_d = BK_ECHO;
			BK_ECHO: if (out_free && !emit) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		ld       = 1'b0;
		kind_d   = KIND_FIELD;
		value_d  = '0;
		byte_d   = '0;
		status_d = STAT_OK;
		last_d   = 1'b1;
		unique case (st_q)
			BK_IDLE: begin
				pop = !qs.empty && out_free;
				if (pop) begin
					if (cmd.op == OP_PUSH) begin
						ld       = 1'b1;
						kind_d   = KIND_PUSH;
						status_d = (cons_q >= 7'd8) ? STAT_OK : STAT_FULL;
					end else if (under) begin
						ld       = 1'b1;
						status_d = STAT_UNDERRUN;
					end else if (cmd.op != OP_ECHO) begin
						ld      = 1'b1;
						value_d = field[56:0];
					end
				end
			end
			BK_ECHO: begin
				if (out_free) begin
					ld = 1'b1;
					if (emit) begin
						kind_d = KIND_ECHO;
						byte_d = echo_b;
						last_d = 1'b0;
					end else begin
						value_d = val_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= BK_IDLE;
			buf_q  <= '0;
			cons_q <= BB7;
			ov_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			if (ld) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;
			if (pop) begin
				if (cmd.op == OP_PUSH) begin
					if (cons_q >= 7'd8) begin
						buf_q  <= {buf_q[55:0], cmd.data_b};
						cons_q <= cons_q - 7'd8;
					end
				end else if (!under && (cmd.op == OP_READ || cmd.op == OP_ECHO)) begin
					cons_q <= cons_q + {1'b0, cmd.n};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_echo) begin
			sh_q  <= {1'b0, (avail - 7'd1) & 7'h78};
			lo_q  <= lo;
			val_q <= field[56:0];
		end else if (st_q == BK_ECHO && out_free && emit) begin
			sh_q <= sh_q - 8'd8;
		end
		if (ld) begin
			kind_q   <= kind_d;
			value_q  <= value_d;
			byte_q   <= byte_d;
			status_q <= status_d;
			last_q   <= last_d;
		end
	end

	assign rsp.valid    = ov_q;
	assign rsp.kind     = kind_q;
	assign rsp.value    = value_q;
	assign rsp.byte_out = byte_q;
	assign rsp.status   = status_q;
	assign rsp.last     = last_q;

	`MSBR_ASSERT(a_cons_range, cons_q <= BB7, "consumed position beyond buffer")
	`MSBR_ASSERT_IMP(a_sh_align, st_q == BK_ECHO, sh_q[7] || (sh_q[2:0] == 3'd0),
		"echo shift not on a byte boundary")
	`MSBR_ASSERT_NXT(a_buf_hold, st_q == BK_ECHO, $stable(buf_q), "buffer changed during echo")

endmodule

### src/msb_bit_reader.sv
// Channel  Dir  Item
// req      in   func, byte_in, n_bits
// rsp      out  kind, value, byte_out, status, last
//
// Push, read and peek items give one result each; the back part takes one
// command a cycle from a two-entry queue while the result register is free
// and no echo is running. Read with echo holds the back part while it sets
// up, gives one result per echoed byte (up to 8) and then the field result.
// Reset empties the buffer at once; no clearing pass.
// A stalled result holds the back part; the queue keeps taking items until full.
// Top level of the MSB-first bit reader; depends on msbr_pkg, the channel
// interfaces, msbr_front, msbr_queue and msbr_back.
`timescale 1ns / 1ps

module msb_bit_reader import msbr_pkg::*; #(
	parameter int BUFFER_BITS = BUFFER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	msbr_in_if.sink     req,
	msbr_out_if.source  rsp
);

	q_stat_t qs;
	logic    push;
	logic    pop;
	cmd_t    wr_cmd;
	cmd_t    rd_cmd;

	msbr_front #(.BUFFER_BITS(BUFFER_BITS)) u_front (
		.req  (req),
		.qs   (qs),
		.push (push),
		.cmd  (wr_cmd)
	);

	msbr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.qs     (qs)
	);

	msbr_back #(.BUFFER_BITS(BUFFER_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rd_cmd),
		.qs     (qs),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

### bench/msbr_checker.sv
// Result checker of the bit reader: predicts every result from the request items
// it sees and compares the result items field by field. Depends on msbr_pkg
// and the two channel interfaces.
`timescale 1ns / 1ps

module msbr_checker import msbr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	msbr_in_if   req,
	msbr_out_if  rsp,
	output int   errors,
	output int   pending,
	output int   results_seen,
	output int   echoes_seen
);

	localparam int BITS = BUFFER_BITS_DEF;

	typedef struct {
		logic [1:0]  kind;
		logic [56:0] value;
		logic [7:0]  byte_out;
		logic [1:0]  status;
		logic        last;
	} reader_result_t;

	reader_result_t due_results[$];
	logic [63:0]    shift_reg;
	logic [6:0]     bits_used;

	function automatic reader_result_t mk_result(logic [1:0] kind, logic [56:0] value,
		logic [7:0] b, logic [1:0] status, logic last);
		reader_result_t r;
		r.kind     = kind;
		r.value    = value;
		r.byte_out = b;
		r.status   = status;
		r.last     = last;
		return r;
	endfunction

	task automatic predict_reader(input logic [1:0] f, input logic [7:0] b,
		input logic [5:0] n);
		int          used;
		int          avail;
		int          cnt;
		logic [63:0] field;
		used  = int'(bits_used);
		cnt   = int'(n);
		avail = (used <= BITS) ? BITS - used : 0;
		if (f == FUNC_PUSH) begin
			if (used >= 8) begin
				shift_reg = {shift_reg[55:0], b};
				bits_used = 7'(used - 8);
				due_results.push_back(mk_result(KIND_PUSH, '0, '0, STAT_OK, 1'b1));
			end else begin
				due_results.push_back(mk_result(KIND_PUSH, '0, '0, STAT_FULL, 1'b1));
			end
		end else if (cnt == 0 || cnt > BITS - 7 || cnt > avail) begin
			due_results.push_back(mk_result(KIND_FIELD, '0, '0, STAT_UNDERRUN, 1'b1));
		end else begin
			field = (shift_reg >> (avail - cnt)) & ((64'd1 << cnt) - 64'd1);
			if (f == FUNC_ECHO) begin
				for (int p = used + 1; p <= used + cnt; p++) begin
					if (((BITS - p) & 7) == 0)
						due_results.push_back(mk_result(KIND_ECHO, '0,
							8'(shift_reg >> (BITS - p)), STAT_OK, 1'b0));
				end
			end
			if (f != FUNC_PEEK)
				bits_used = 7'(used + cnt);
			due_results.push_back(mk_result(KIND_FIELD, field[56:0], '0, STAT_OK, 1'b1));
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reader_result_t want;
		if (!arst_n) begin
			due_results.delete();
			shift_reg    = '0;
			bits_used    = 7'(BITS);
			errors       = 0;
			pending      = 0;
			results_seen = 0;
			echoes_seen  = 0;
		end else begin
			if (req.valid && req.ready)
				predict_reader(req.func, req.byte_in, req.n_bits);
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (rsp.kind == KIND_ECHO)
					echoes_seen++;
				if (due_results.size() == 0) begin
					$error("result item with none expected: kind %0d value 'h%0h",
						rsp.kind, rsp.value);
					errors++;
				end else begin
					want = due_results.pop_front();
					check_field("kind", 64'(want.kind), 64'(rsp.kind));
					check_field("value", 64'(want.value), 64'(rsp.value));
					check_field("byte_out", 64'(want.byte_out), 64'(rsp.byte_out));
					check_field("status", 64'(want.status), 64'(rsp.status));
					check_field("last", 64'(want.last), 64'(rsp.last));
				end
			end
			pending = due_results.size();
		end
	end

endmodule

### bench/msb_bit_reader_tb.sv
// Top of the bit reader testbench: clock, reset, request and result traffic,
// verdict. Depends on msbr_pkg, the channel interfaces, msb_bit_reader and msbr_checker.
`timescale 1ns / 1ps

module msb_bit_reader_tb;
	import msbr_pkg::*;

	localparam int BITS      = BUFFER_BITS_DEF;
	localparam int NUM_ITEMS = 380;
	localparam int HOLD_CYC  = 80;

	logic clk;
	logic arst_n;

	msbr_in_if  req();
	msbr_out_if rsp();

	int  errors;
	int  pending;
	int  results_seen;
	int  echoes_seen;
	int  sent;
	int  pushes;
	int  fill;
	bit  gaps_on;
	bit  hold_req;

	msb_bit_reader dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	msbr_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen),
		.echoes_seen  (echoes_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#4_800_000;
		$display("msb_bit_reader: mismatch");
		$finish;
	end

	task automatic send_item(input logic [1:0] f, input logic [7:0] b, input logic [5:0] n);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req.valid   <= 1'b1;
		req.func    <= f;
		req.byte_in <= b;
		req.n_bits  <= n;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sent++;
		if (f == FUNC_PUSH) begin
			pushes++;
			if (fill <= BITS - 8)
				fill += 8;
		end else if (f != FUNC_PEEK && n != 0 && n <= BITS - 7 && n <= fill) begin
			fill -= n;
		end
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		rsp.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int  roll;
		int  burst;
		int  top_n;
		int  waited;
		bit  hold_armed;
		sent       = 0;
		pushes     = 0;
		fill       = 0;
		gaps_on    = 1'b1;
		hold_req   = 1'b0;
		hold_armed = 1'b0;
		arst_n      <= 1'b0;
		req.valid   <= 1'b0;
		req.func    <= FUNC_PUSH;
		req.byte_in <= '0;
		req.n_bits  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty buffer, full buffer, range limits, a read that echoes all eight bytes
		send_item(FUNC_READ, 8'h00, 6'd1);
		send_item(FUNC_PEEK, 8'hFF, 6'd1);
		send_item(FUNC_ECHO, 8'h00, 6'd8);
		send_item(FUNC_PUSH, 8'hFF, 6'd63);
		send_item(FUNC_PUSH, 8'h00, 6'd0);
		send_item(FUNC_PUSH, 8'hA5, 6'd5);
		send_item(FUNC_PUSH, 8'h5A, 6'd42);
		send_item(FUNC_PUSH, 8'h80, 6'd1);
		send_item(FUNC_PUSH, 8'h01, 6'd7);
		send_item(FUNC_PUSH, 8'h3C, 6'd57);
		send_item(FUNC_PUSH, 8'hC3, 6'd21);
		send_item(FUNC_PUSH, 8'h77, 6'd9);
		send_item(FUNC_PEEK, 8'h00, 6'd57);
		send_item(FUNC_READ, 8'h00, 6'd0);
		send_item(FUNC_PEEK, 8'h00, 6'd63);
		send_item(FUNC_READ, 8'h00, 6'd58);
		send_item(FUNC_READ, 8'h00, 6'd7);
		send_item(FUNC_ECHO, 8'h00, 6'd57);
		send_item(FUNC_PUSH, 8'h96, 6'd0);
		send_item(FUNC_ECHO, 8'h00, 6'd9);
		send_item(FUNC_ECHO, 8'h00, 6'd8);

		while (sent < NUM_ITEMS) begin
			if (sent >= NUM_ITEMS - 60)
				gaps_on = 1'b0;
			if (sent >= 180 && !hold_armed) begin
				hold_armed = 1'b1;
				hold_req   = 1'b1;
			end
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				send_item(2'($urandom_range(0, 3)), 8'($urandom),
					6'($urandom_range(0, 63)));
			end else if (fill < 8 || roll < 35) begin
				burst = (BITS - fill) / 8 + ($urandom_range(0, 3) == 0);
				if (burst == 0)
					burst = 1;
				repeat (burst) send_item(FUNC_PUSH, 8'($urandom), 6'($urandom));
			end else begin
				top_n = (fill < BITS - 7) ? fill : BITS - 7;
				send_item(2'($urandom_range(1, 3)), 8'($urandom),
					6'($urandom_range(1, top_n)));
			end
		end
		req.valid <= 1'b0;

		waited = 0;
		while (pending != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);

		$display("Ran %0d request items (%0d pushes) through the reader;", sent, pushes);
		$display("checked %0d result items, %0d of them echoed bytes.",
			results_seen, echoes_seen);
		if (errors == 0 && pending == 0) begin
			$display("msb_bit_reader: match");
		end else begin
			$display("msb_bit_reader: mismatch");
		end
		$finish;
	end

endmodule

### msb_bit_reader.f
+incdir+src
src/msbr_pkg.sv
src/msbr_in_if.sv
src/msbr_out_if.sv
src/msbr_front.sv
src/msbr_queue.sv
src/msbr_back.sv
src/msb_bit_reader.sv
bench/msbr_checker.sv
bench/msb_bit_reader_tb.sv
